// ===== src/max_triangle_window_sum_macros.svh =====
// Assertion macros shared by the max_triangle_window_sum RTL.
// The macros expect signals named clk and rst_n in the using module.
`ifndef MAX_TRIANGLE_WINDOW_SUM_MACROS_SVH
`define MAX_TRIANGLE_WINDOW_SUM_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define MTWS_ASSERT_IMP(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define MTWS_ASSERT_NXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define MTWS_ASSERT_IMP(lbl, a, b, msg)
`define MTWS_ASSERT_NXT(lbl, a, b, msg)
`endif
`endif

// ===== src/mtws_pkg.sv =====
// Package for max_triangle_window_sum: types, sizes and table addressing.
// No dependencies.
`timescale 1ns / 1ps
package mtws_pkg;
  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 256;
  localparam int ROW_AW   = $clog2(MAX_ROWS);
  localparam int COL_AW   = $clog2(MAX_COLS);
  localparam int TBL_AW   = ROW_AW + COL_AW;
  localparam int DIM_W    = 9;
  localparam int CELL_W   = 16;
  localparam int SUM_W    = 42;
  localparam int PH_W     = 4;
  localparam logic [PH_W-1:0] PH_LAST_BUILD = 4'd8;
  localparam logic [PH_W-1:0] PH_LAST_EVAL  = 4'd5;
  localparam logic signed [SUM_W-1:0] MOST_NEG = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [1:0] {REG_ROWS = 2'd0, REG_COLS = 2'd1, REG_SIDE = 2'd2} reg_idx_t;
  typedef enum logic [2:0] {S_LOAD, S_BR, S_BL, S_EVR, S_EVL, S_DONE} state_t;
  typedef enum logic [2:0] {SRC_NONE, SRC_CELL, SRC_RR, SRC_TR, SRC_RL, SRC_TL} src_t;
  typedef enum logic [2:0] {ALU_NONE, ALU_LOAD, ALU_ADD, ALU_SUB, ALU_TAKE} alu_op_t;

  typedef struct packed {
    alu_op_t op;
    logic    clear;
  } alu_ctl_t;

  // Table entry (row, col), both 1-based, packed as row-major address.
  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [DIM_W-1:0] row,
                                                 input logic [DIM_W-1:0] col);
    logic [DIM_W-1:0] r1;
    logic [DIM_W-1:0] c1;
    r1 = row - DIM_W'(1);
    c1 = col - DIM_W'(1);
    return {r1[ROW_AW-1:0], c1[COL_AW-1:0]};
  endfunction
endpackage

// ===== src/mtws_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module mtws_ram #(
  parameter int W  = 16,
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [W-1:0]  wdata,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [2**AW];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;
endmodule

// ===== src/mtws_alu.sv =====
// Shared accumulator: load, add, subtract and running-maximum compare.
// Depends on mtws_pkg.
`timescale 1ns / 1ps
module mtws_alu (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mtws_pkg::alu_ctl_t            ctl,
  input  logic signed [mtws_pkg::SUM_W-1:0] operand,
  output logic signed [mtws_pkg::SUM_W-1:0] best,
  output logic                          found
);
  import mtws_pkg::*;

  logic signed [SUM_W-1:0] acc_r, acc_nxt;
  logic signed [SUM_W-1:0] best_r, best_nxt;
  logic                    found_r, found_nxt;

  always_comb begin
    acc_nxt   = acc_r;
    best_nxt  = best_r;
    found_nxt = found_r;
    case (ctl.op)
      ALU_LOAD: acc_nxt = operand;
      ALU_ADD:  acc_nxt = acc_r + operand;
      ALU_SUB:  acc_nxt = acc_r - operand;
      ALU_TAKE: begin
        if (!found_r || (acc_r > best_r)) begin
          best_nxt = acc_r;
        end
        found_nxt = 1'b1;
      end
      default: ;
    endcase
    if (ctl.clear) begin
      best_nxt  = MOST_NEG;
      found_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (!rst_n) begin
      best_r  <= MOST_NEG;
      found_r <= 1'b0;
    end else begin
      best_r  <= best_nxt;
      found_r <= found_nxt;
    end
  end

  assign best  = best_r;
  assign found = found_r;
endmodule

// ===== src/max_triangle_window_sum.sv =====
// Top level of max_triangle_window_sum: sequencer, table RAMs and shared accumulator.
// Depends on mtws_pkg, mtws_ram, mtws_alu and the macro header.
// After the last word of an R x C grid, each cell is built into the right and left tables,
// then each cell's right and left triangles are summed where they fit; the result follows.
// Throughput: one word per cycle while busy is low; busy stays high until the result is shown.
// rst_n is synchronous and restores all dimensions to 1 and the load position to 0.
`timescale 1ns / 1ps
`include "max_triangle_window_sum_macros.svh"
module max_triangle_window_sum (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [mtws_pkg::CELL_W-1:0] in_cell_value,
  output logic                              out_valid,
  output logic signed [mtws_pkg::SUM_W-1:0]  out_best_sum,
  output logic                              out_found,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [mtws_pkg::DIM_W-1:0]         cfg_wdata
);
  import mtws_pkg::*;

  // Configuration registers, reset to 1.
  logic [DIM_W-1:0] rows_cfg_r, cols_cfg_r, side_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= DIM_W'(1);
      cols_cfg_r <= DIM_W'(1);
      side_cfg_r <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS: rows_cfg_r <= cfg_wdata;
        REG_COLS: cols_cfg_r <= cfg_wdata;
        REG_SIDE: side_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective dimensions: zero reads as one, oversize rows and columns saturate.
  logic [DIM_W-1:0] rows, cols, side;
  always_comb begin
    rows = (rows_cfg_r == '0) ? DIM_W'(1) :
           (rows_cfg_r > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_cfg_r;
    cols = (cols_cfg_r == '0) ? DIM_W'(1) :
           (cols_cfg_r > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_cfg_r;
    side = (side_cfg_r == '0) ? DIM_W'(1) : side_cfg_r;
  end

  // Sequencer state.
  state_t           state_r, state_nxt;
  logic [DIM_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [PH_W-1:0]  ph_r, ph_nxt;
  logic [15:0]      pos_r, pos_nxt;
  logic [15:0]      base_r, base_nxt;

  logic        accept, complete;
  logic [16:0] total, pos_inc;

  assign busy     = (state_r != S_LOAD);
  assign accept   = start && !busy;
  assign total    = 17'(rows * cols);
  assign pos_inc  = {1'b0, pos_r} + 17'd1;
  assign complete = accept && (pos_inc >= total);

  // Neighbor coordinates used by the build and evaluation passes.
  logic [DIM_W-1:0] im1, jm1, jp1, imk, jmk, jpk;
  logic [DIM_W:0]   jpk_w;
  logic             fit_r_tri, fit_l_tri;
  assign im1   = i_r - DIM_W'(1);
  assign jm1   = j_r - DIM_W'(1);
  assign jp1   = j_r + DIM_W'(1);
  assign imk   = i_r - side;
  assign jmk   = j_r - side;
  assign jpk_w = {1'b0, j_r} + {1'b0, side};
  assign jpk   = jpk_w[DIM_W-1:0];
  assign fit_r_tri = (i_r >= side) && (j_r >= side);
  assign fit_l_tri = (i_r >= side) && (jpk_w <= ({1'b0, cols} + (DIM_W+1)'(1)));

  // Per-phase control: at most one read, one optional write and one accumulator op.
  src_t             rd_src, wr_dst;
  logic [DIM_W-1:0] rd_row, rd_col;
  alu_ctl_t         alu_ctl;
  logic             last;

  always_comb begin
    rd_src      = SRC_NONE;
    wr_dst      = SRC_NONE;
    rd_row      = i_r;
    rd_col      = j_r;
    alu_ctl.op  = ALU_NONE;
    alu_ctl.clear = complete;
    last        = 1'b0;
    case (state_r)
      S_BR, S_BL: begin
        // Rectangle entry first, then the triangle entry built on it.
        case (ph_r)
          4'd0: rd_src = SRC_CELL;
          4'd1: begin
            rd_src = (state_r == S_BR) ? SRC_RR : SRC_RL;
            rd_row = im1;
            alu_ctl.op = ALU_LOAD;
          end
          4'd2: begin
            rd_src = (state_r == S_BR) ? SRC_RR : SRC_RL;
            rd_col = (state_r == S_BR) ? jm1 : jp1;
            alu_ctl.op = ALU_ADD;
          end
          4'd3: begin
            rd_src = (state_r == S_BR) ? SRC_RR : SRC_RL;
            rd_row = im1;
            rd_col = (state_r == S_BR) ? jm1 : jp1;
            alu_ctl.op = ALU_ADD;
          end
          4'd4: begin
            rd_src = (state_r == S_BR) ? SRC_TR : SRC_TL;
            rd_row = im1;
            rd_col = (state_r == S_BR) ? jm1 : jp1;
            alu_ctl.op = ALU_SUB;
          end
          4'd5: begin
            wr_dst = (state_r == S_BR) ? SRC_RR : SRC_RL;
            alu_ctl.op = ALU_ADD;
          end
          4'd6: begin
            rd_src = (state_r == S_BR) ? SRC_RR : SRC_RL;
            rd_row = im1;
          end
          4'd7: alu_ctl.op = ALU_SUB;
          default: begin
            wr_dst = (state_r == S_BR) ? SRC_TR : SRC_TL;
            last   = 1'b1;
          end
        endcase
      end
      S_EVR, S_EVL: begin
        if (((state_r == S_EVR) && !fit_r_tri) || ((state_r == S_EVL) && !fit_l_tri)) begin
          last = 1'b1;
        end else begin
          case (ph_r)
            4'd0: rd_src = (state_r == S_EVR) ? SRC_TR : SRC_TL;
            4'd1: begin
              rd_src = (state_r == S_EVR) ? SRC_TR : SRC_TL;
              rd_row = imk;
              rd_col = (state_r == S_EVR) ? jmk : jpk;
              alu_ctl.op = ALU_LOAD;
            end
            4'd2: begin
              rd_src = (state_r == S_EVR) ? SRC_RR : SRC_RL;
              rd_col = (state_r == S_EVR) ? jmk : jpk;
              alu_ctl.op = ALU_SUB;
            end
            4'd3: begin
              rd_src = (state_r == S_EVR) ? SRC_RR : SRC_RL;
              rd_row = imk;
              rd_col = (state_r == S_EVR) ? jmk : jpk;
              alu_ctl.op = ALU_SUB;
            end
            4'd4: alu_ctl.op = ALU_ADD;
            default: begin
              alu_ctl.op = ALU_TAKE;
              last = 1'b1;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  // Next state and loop counters.
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    ph_nxt    = last ? '0 : ph_r + PH_W'(1);
    pos_nxt   = pos_r;
    base_nxt  = base_r;
    case (state_r)
      S_LOAD: begin
        ph_nxt = '0;
        if (accept) begin
          pos_nxt = pos_inc[15:0];
          if (complete) begin
            pos_nxt   = '0;
            state_nxt = S_BR;
            i_nxt     = DIM_W'(1);
            j_nxt     = DIM_W'(1);
            base_nxt  = '0;
          end
        end
      end
      S_BR: begin
        if (last) begin
          if (j_r == cols) begin
            state_nxt = S_BL;
          end else begin
            j_nxt = jp1;
          end
        end
      end
      S_BL: begin
        if (last) begin
          if (j_r == DIM_W'(1)) begin
            if (i_r == rows) begin
              state_nxt = S_EVR;
              i_nxt     = DIM_W'(1);
            end else begin
              state_nxt = S_BR;
              i_nxt     = i_r + DIM_W'(1);
              base_nxt  = base_r + 16'(cols);
            end
          end else begin
            j_nxt = jm1;
          end
        end
      end
      S_EVR: begin
        if (last) begin
          state_nxt = S_EVL;
        end
      end
      S_EVL: begin
        if (last) begin
          state_nxt = S_EVR;
          if (j_r == cols) begin
            j_nxt = DIM_W'(1);
            if (i_r == rows) begin
              state_nxt = S_DONE;
            end else begin
              i_nxt = i_r + DIM_W'(1);
            end
          end else begin
            j_nxt = jp1;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
        ph_nxt    = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      ph_r    <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      pos_r   <= pos_nxt;
    end
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    base_r <= base_nxt;
  end

  // Memories: the loaded cells and the four prefix tables.
  logic [CELL_W-1:0] cell_rd;
  logic [15:0]       cell_addr;
  logic [SUM_W-1:0]  rr_rd, tr_rd, rl_rd, tl_rd;
  logic [SUM_W-1:0]  acc_w;
  logic [TBL_AW-1:0] rd_addr, wr_addr;

  assign cell_addr = accept ? pos_r : (base_r + 16'(jm1));
  assign rd_addr   = tbl_addr(rd_row, rd_col);
  assign wr_addr   = tbl_addr(i_r, j_r);

  mtws_ram #(.W(CELL_W), .AW(16)) u_cell (
    .clk(clk), .we(accept), .addr(cell_addr), .wdata(in_cell_value), .rdata(cell_rd)
  );
  mtws_ram #(.W(SUM_W), .AW(TBL_AW)) u_rr (
    .clk(clk), .we(wr_dst == SRC_RR), .addr((wr_dst == SRC_RR) ? wr_addr : rd_addr),
    .wdata(acc_w), .rdata(rr_rd)
  );
  mtws_ram #(.W(SUM_W), .AW(TBL_AW)) u_tr (
    .clk(clk), .we(wr_dst == SRC_TR), .addr((wr_dst == SRC_TR) ? wr_addr : rd_addr),
    .wdata(acc_w), .rdata(tr_rd)
  );
  mtws_ram #(.W(SUM_W), .AW(TBL_AW)) u_rl (
    .clk(clk), .we(wr_dst == SRC_RL), .addr((wr_dst == SRC_RL) ? wr_addr : rd_addr),
    .wdata(acc_w), .rdata(rl_rd)
  );
  mtws_ram #(.W(SUM_W), .AW(TBL_AW)) u_tl (
    .clk(clk), .we(wr_dst == SRC_TL), .addr((wr_dst == SRC_TL) ? wr_addr : rd_addr),
    .wdata(acc_w), .rdata(tl_rd)
  );

  // A read on the grid border stands for zero; the flag follows the read data.
  src_t src_q_r;
  logic zero_q_r;
  always_ff @(posedge clk) begin
    src_q_r  <= rd_src;
    zero_q_r <= (rd_row == '0) || (rd_col == '0) ||
                ({1'b0, rd_col} == ({1'b0, cols} + (DIM_W+1)'(1)));
  end

  logic signed [SUM_W-1:0] operand;
  always_comb begin
    case (src_q_r)
      SRC_CELL: operand = {{(SUM_W-CELL_W){cell_rd[CELL_W-1]}}, cell_rd};
      SRC_RR:   operand = rr_rd;
      SRC_TR:   operand = tr_rd;
      SRC_RL:   operand = rl_rd;
      SRC_TL:   operand = tl_rd;
      default:  operand = '0;
    endcase
    if (zero_q_r && (src_q_r != SRC_CELL)) begin
      operand = '0;
    end
  end

  // The alu keeps the best sum and found flag; the table write port takes the shadow below.
  logic signed [SUM_W-1:0] best;
  logic                    found;
  logic signed [SUM_W-1:0] acc_shadow_r;

  mtws_alu u_alu (
    .clk(clk), .rst_n(rst_n), .ctl(alu_ctl), .operand(operand),
    .best(best), .found(found)
  );

  // Shadow of the accumulator, kept here for the table write port.
  always_ff @(posedge clk) begin
    case (alu_ctl.op)
      ALU_LOAD: acc_shadow_r <= operand;
      ALU_ADD:  acc_shadow_r <= acc_shadow_r + operand;
      ALU_SUB:  acc_shadow_r <= acc_shadow_r - operand;
      default: ;
    endcase
  end
  assign acc_w = acc_shadow_r;

  // Result word, shown for one cycle.
  assign out_valid    = (state_r == S_DONE);
  assign out_found    = found;
  assign out_best_sum = found ? best : '0;

  `MTWS_ASSERT_NXT(a_strobe_single, out_valid, !out_valid, "result strobe longer than one cycle")
  `MTWS_ASSERT_IMP(a_zero_if_none, out_valid && !out_found, out_best_sum == '0,
                   "best_sum not zero without a triangle")
  `MTWS_ASSERT_IMP(a_busy_fall, $fell(busy), $past(out_valid), "busy fell without a result")
  `MTWS_ASSERT_NXT(a_complete_busy, complete, busy && !found, "evaluation did not start clean")
endmodule

// ===== sim/tb_max_triangle_window_sum.sv =====
// Testbench for max_triangle_window_sum: loads grids word by word and checks each result.
// Depends on mtws_pkg and the max_triangle_window_sum RTL.
`timescale 1ns / 1ps
module tb_max_triangle_window_sum;
  import mtws_pkg::*;

  // Index past the end of the register list; the block must ignore writes to it.
  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int ITEM_TARGET = 1350;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CELL_W-1:0] in_cell_value = '0;
  logic out_valid;
  logic signed [SUM_W-1:0] out_best_sum;
  logic out_found;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_wdata = '0;

  max_triangle_window_sum dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cell_value(in_cell_value), .out_valid(out_valid),
    .out_best_sum(out_best_sum), .out_found(out_found),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  typedef struct {
    logic signed [SUM_W-1:0] best_sum;
    bit found;
  } window_result_t;

  typedef struct {
    bit is_cfg;
    logic [1:0] idx;
    int value;
    bit typed;
    longint exp_sum;
    bit exp_found;
  } stim_row_t;

  window_result_t pending_results[$];
  shortint grid_cells[$];
  logic [DIM_W-1:0] rows_reg = 9'd1;
  logic [DIM_W-1:0] cols_reg = 9'd1;
  logic [DIM_W-1:0] side_reg = 9'd1;
  int error_count = 0;
  int idle_cycles = 0;
  int items_sent = 0;

  // Registers as the block uses them: zero means one, rows and columns saturate.
  function automatic int eff_dim(logic [DIM_W-1:0] v, int hi);
    if (v == 0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  // Direct sum over every fitting triangle of the loaded grid.
  function automatic window_result_t best_triangle();
    window_result_t r;
    int rows, cols, k;
    longint s, best;
    bit any;
    rows = eff_dim(rows_reg, MAX_ROWS);
    cols = eff_dim(cols_reg, MAX_COLS);
    k = (side_reg == 0) ? 1 : int'(side_reg);
    any = 0;
    best = 0;
    for (int i = k; i <= rows; i++) begin
      for (int j = 1; j <= cols; j++) begin
        if (j >= k) begin
          s = 0;
          for (int d = 0; d < k; d++)
            for (int c = j - k + 1; c <= j - d; c++)
              s += grid_cells[(i - d - 1) * cols + c - 1];
          if (!any || s > best) best = s;
          any = 1;
        end
        if (j + k <= cols + 1) begin
          s = 0;
          for (int d = 0; d < k; d++)
            for (int c = j + d; c <= j + k - 1; c++)
              s += grid_cells[(i - d - 1) * cols + c - 1];
          if (!any || s > best) best = s;
          any = 1;
        end
      end
    end
    r.best_sum = any ? SUM_W'(best) : '0;
    r.found = any;
    return r;
  endfunction

  // Holds start low and waits until every result is in, plus slack for the block
  // to settle back to idle.
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= DIM_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ROWS: rows_reg = DIM_W'(value);
      REG_COLS: cols_reg = DIM_W'(value);
      REG_SIDE: side_reg = DIM_W'(value);
      default: ;
    endcase
  endtask

  // Sends one cell word. Start is only lowered when a gap follows, so a back-to-back
  // word never sees start dropped and raised in the same step.
  task automatic send_cell(shortint v, bit typed, longint exp_sum, bit exp_found);
    int gap;
    bit took;
    window_result_t r;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_cell_value <= v;
    took = 0;
    while (!took) begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end
    items_sent++;
    grid_cells.push_back(v);
    if (grid_cells.size() >= eff_dim(rows_reg, MAX_ROWS) * eff_dim(cols_reg, MAX_COLS)) begin
      if (typed) begin
        r.best_sum = SUM_W'(exp_sum);
        r.found = exp_found;
      end else begin
        r = best_triangle();
      end
      pending_results.push_back(r);
      grid_cells.delete();
    end
  endtask

  function automatic shortint rand_cell();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return -16'sh8000;
      2: return 16'(int'($urandom_range(0, 20)) - 10);
      default: return shortint'($urandom());
    endcase
  endfunction

  // Outputs and busy are sampled mid-cycle, away from the edge where they change.
  always @(negedge clk) begin
    window_result_t e;
    if (rst_n && ((start && !busy) || out_valid)) idle_cycles = 0;
    else idle_cycles++;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result best_sum=%0d found=%0d", $time,
                 out_best_sum, out_found);
        error_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_best_sum !== e.best_sum) begin
          $display("%0t: best_sum expected %0d actual %0d", $time, e.best_sum,
                   out_best_sum);
          error_count++;
        end
        if (out_found !== e.found) begin
          $display("%0t: found expected %0d actual %0d", $time, e.found, out_found);
          error_count++;
        end
      end
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  stim_row_t directed[$];

  function automatic stim_row_t cfg_row(logic [1:0] idx, int value);
    stim_row_t t;
    t = '{1, idx, value, 0, 0, 0};
    return t;
  endfunction

  function automatic stim_row_t cell_row(int value, bit typed, longint s, bit f);
    stim_row_t t;
    t = '{0, REG_NONE, value, typed, s, f};
    return t;
  endfunction

  initial begin
    int rows, cols, side;
    // After reset every grid is a single cell and the lone triangle is that cell.
    directed.push_back(cell_row(32767, 1, 32767, 1));
    directed.push_back(cell_row(-32768, 1, -32768, 1));
    directed.push_back(cell_row(0, 1, 0, 1));
    // A side larger than the grid: nothing fits, so the sum reads zero.
    directed.push_back(cfg_row(REG_SIDE, 2));
    directed.push_back(cell_row(1234, 1, 0, 0));
    // A side of zero is taken as one.
    directed.push_back(cfg_row(REG_SIDE, 0));
    directed.push_back(cell_row(-1, 1, -1, 1));
    // Zero rows and zero columns count as one.
    directed.push_back(cfg_row(REG_ROWS, 0));
    directed.push_back(cfg_row(REG_COLS, 0));
    directed.push_back(cell_row(-7, 1, -7, 1));
    // A write past the register list changes nothing.
    directed.push_back(cfg_row(REG_NONE, 300));
    directed.push_back(cell_row(9, 1, 9, 1));
    // A 2 x 3 grid with side 2, mixing extremes.
    directed.push_back(cfg_row(REG_ROWS, 2));
    directed.push_back(cfg_row(REG_COLS, 3));
    directed.push_back(cfg_row(REG_SIDE, 2));
    directed.push_back(cell_row(32767, 0, 0, 0));
    directed.push_back(cell_row(-32768, 0, 0, 0));
    directed.push_back(cell_row(5, 0, 0, 0));
    directed.push_back(cell_row(32767, 0, 0, 0));
    directed.push_back(cell_row(32767, 0, 0, 0));
    directed.push_back(cell_row(-3, 0, 0, 0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[n]) begin
      if (directed[n].is_cfg) begin
        wait_drained();
        write_reg(directed[n].idx, directed[n].value);
      end else begin
        send_cell(shortint'(directed[n].value), directed[n].typed, directed[n].exp_sum,
                  directed[n].exp_found);
      end
    end

    // Random phases: mostly small grids, now and then a tall or wide one at full size.
    while (items_sent < ITEM_TARGET) begin
      rows = $urandom_range(0, 6);
      cols = $urandom_range(0, 6);
      side = $urandom_range(0, 7);
      case ($urandom_range(0, 29))
        0: begin rows = ($urandom_range(0, 1) != 0) ? 511 : 256; cols = 1; end
        1: begin rows = 1; cols = ($urandom_range(0, 1) != 0) ? 256 : 300; end
        2: side = ($urandom_range(0, 1) != 0) ? 511 : 256;
        default: ;
      endcase
      if (rows > 6 || cols > 6) side = $urandom_range(0, 3);
      wait_drained();
      write_reg(REG_ROWS, rows);
      write_reg(REG_COLS, cols);
      write_reg(REG_SIDE, side);
      if ($urandom_range(0, 9) == 0) write_reg(REG_NONE, $urandom_range(0, 511));
      for (int n = 0;
           n < eff_dim(DIM_W'(rows), MAX_ROWS) * eff_dim(DIM_W'(cols), MAX_COLS); n++)
        send_cell(rand_cell(), 0, 0, 0);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== max_triangle_window_sum.f =====
+incdir+src
src/mtws_pkg.sv
src/mtws_ram.sv
src/mtws_alu.sv
src/max_triangle_window_sum.sv
sim/tb_max_triangle_window_sum.sv
